// ===== rtl/mrsd_pkg.sv =====
// shared types and constants for the multi-rate sensor dispatcher
package mrsd_pkg;

  localparam int MAX_SENSORS_DEF = 16;

  localparam logic [15:0] MICROS_PER_TICK_RST = 16'd1000;
  localparam logic [10:0] TICKS_PER_SECOND    = 11'd1000;
  localparam logic [10:0] TEN_MS              = 11'd10;
  localparam logic [10:0] HUNDRED_MS          = 11'd100;
  localparam logic [4:0]  RESULT_CAP          = 5'd16;

  localparam logic OP_STAMP    = 1'b0;
  localparam logic OP_REGISTER = 1'b1;

  localparam logic [1:0] RATE_1MS   = 2'd0;
  localparam logic [1:0] RATE_10MS  = 2'd1;
  localparam logic [1:0] RATE_100MS = 2'd2;
  localparam logic [1:0] RATE_1S    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DELTA,
    S_ACCUM,
    S_CHECK,
    S_FLAGS,
    S_SCAN,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic reg_write;
    logic delta;
    logic accum;
    logic check;
    logic flags;
    logic scan;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic tick;
    logic scan_done;
  } stat_t;

endpackage

// ===== rtl/mrsd_ctrl.sv =====
// controller state machine for the multi-rate sensor dispatcher
module mrsd_ctrl
  import mrsd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  logic  in_op,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_op == OP_REGISTER) begin
            cmd.reg_write = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_DELTA;
          end
        end
      end
      S_DELTA: begin
        cmd.delta = 1'b1;
        state_nxt = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = stat.tick ? S_FLAGS : S_IDLE;
      end
      S_FLAGS: begin
        cmd.flags = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== rtl/mrsd_datapath.sv =====
// timing accumulator, sensor rate memory and due-sensor scan datapath
module mrsd_datapath
  import mrsd_pkg::*;
#(
  parameter int MAX_SENSORS = MAX_SENSORS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic [31:0] in_timestamp_us,
  input  logic [1:0]  in_sensor_rate,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output stat_t       stat,
  output logic        out_valid,
  output logic [3:0]  out_due_sensor,
  output logic [1:0]  out_due_rate,
  output logic        out_last_of_run
);

  localparam int CNT_W = $clog2(MAX_SENSORS + 1);
  localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;

  logic [1:0] rate_mem [MAX_SENSORS];

  logic [15:0]      mpt_r, mpt_nxt;
  logic [31:0]      stamp_r, stamp_nxt;
  logic [31:0]      prev_r, prev_nxt;
  logic [31:0]      delta_r, delta_nxt;
  logic [32:0]      acc_r, acc_nxt;
  logic [10:0]      milli_r, milli_nxt;
  logic [10:0]      mark10_r, mark10_nxt;
  logic [10:0]      mark100_r, mark100_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [3:0]       due_r, due_nxt;
  logic             iss_act_r, iss_act_nxt;
  logic [CNT_W-1:0] rd_addr_r, rd_addr_nxt;
  logic [1:0]       cls_r, cls_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [1:0]       rd_cls_r, rd_cls_nxt;
  logic [1:0]       rd_data_r;
  logic             pend_vld_r, pend_vld_nxt;
  logic [3:0]       pend_idx_r, pend_idx_nxt;
  logic [1:0]       pend_cls_r, pend_cls_nxt;
  logic [4:0]       res_cnt_r, res_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [3:0]       out_sensor_r, out_sensor_nxt;
  logic [1:0]       out_rate_r, out_rate_nxt;
  logic             out_last_r, out_last_nxt;

  logic        tbl_we;
  logic        tick;
  logic        hit;
  logic [3:0]  hit_idx4;
  logic [10:0] gap10;
  logic [10:0] gap100;
  logic        due10;
  logic        due100;
  logic        due1000;
  logic        nxt_found;
  logic [1:0]  nxt_cls;

  if (CNT_W >= 4) begin : g_idx_wide
    assign hit_idx4 = rd_idx_r[3:0];
  end else begin : g_idx_narrow
    assign hit_idx4 = {{(4 - CNT_W){1'b0}}, rd_idx_r};
  end

  assign tick    = (acc_r >= {17'd0, mpt_r});
  assign gap10   = milli_r - mark10_r;
  assign gap100  = milli_r - mark100_r;
  assign due10   = (gap10 >= TEN_MS);
  assign due100  = (gap100 >= HUNDRED_MS);
  assign due1000 = (milli_r >= TICKS_PER_SECOND);
  assign hit     = rd_vld_r && (rd_data_r == rd_cls_r) && (res_cnt_r < RESULT_CAP);

  // next due rate class after the one being scanned
  always_comb begin
    nxt_found = 1'b0;
    nxt_cls   = RATE_1MS;
    for (int k = 1; k < 4; k++) begin
      if (!nxt_found && (2'(k) > cls_r) && due_r[k]) begin
        nxt_found = 1'b1;
        nxt_cls   = 2'(k);
      end
    end
  end

  always_comb begin
    mpt_nxt        = mpt_r;
    stamp_nxt      = stamp_r;
    prev_nxt       = prev_r;
    delta_nxt      = delta_r;
    acc_nxt        = acc_r;
    milli_nxt      = milli_r;
    mark10_nxt     = mark10_r;
    mark100_nxt    = mark100_r;
    total_nxt      = total_r;
    due_nxt        = due_r;
    iss_act_nxt    = iss_act_r;
    rd_addr_nxt    = rd_addr_r;
    cls_nxt        = cls_r;
    rd_vld_nxt     = rd_vld_r;
    rd_idx_nxt     = rd_idx_r;
    rd_cls_nxt     = rd_cls_r;
    pend_vld_nxt   = pend_vld_r;
    pend_idx_nxt   = pend_idx_r;
    pend_cls_nxt   = pend_cls_r;
    res_cnt_nxt    = res_cnt_r;
    out_valid_nxt  = 1'b0;
    out_sensor_nxt = out_sensor_r;
    out_rate_nxt   = out_rate_r;
    out_last_nxt   = out_last_r;
    tbl_we         = 1'b0;

    if (cfg_we) begin
      mpt_nxt = cfg_data;
    end

    if (cmd.reg_write && (total_r < CNT_W'(MAX_SENSORS))) begin
      tbl_we    = 1'b1;
      total_nxt = total_r + CNT_W'(1);
    end

    if (cmd.load) begin
      stamp_nxt = in_timestamp_us;
    end

    if (cmd.delta) begin
      delta_nxt = stamp_r - prev_r;
      prev_nxt  = stamp_r;
    end

    if (cmd.accum) begin
      acc_nxt = acc_r + {1'b0, delta_r};
    end

    if (cmd.check && tick) begin
      acc_nxt   = '0;
      milli_nxt = milli_r + 11'd1;
    end

    if (cmd.flags) begin
      due_nxt = {due1000, due100, due10, 1'b1};
      if (due10) begin
        mark10_nxt = milli_r;
      end
      if (due100) begin
        mark100_nxt = milli_r;
      end
      if (due1000) begin
        milli_nxt   = '0;
        mark10_nxt  = '0;
        mark100_nxt = '0;
      end
      iss_act_nxt  = (total_r != '0);
      rd_addr_nxt  = '0;
      cls_nxt      = RATE_1MS;
      rd_vld_nxt   = 1'b0;
      pend_vld_nxt = 1'b0;
      res_cnt_nxt  = '0;
    end

    if (cmd.scan) begin
      rd_vld_nxt = iss_act_r;
      rd_idx_nxt = rd_addr_r;
      rd_cls_nxt = cls_r;
      if (iss_act_r) begin
        if (rd_addr_r == (total_r - CNT_W'(1))) begin
          rd_addr_nxt = '0;
          if (nxt_found) begin
            cls_nxt = nxt_cls;
          end else begin
            iss_act_nxt = 1'b0;
          end
        end else begin
          rd_addr_nxt = rd_addr_r + CNT_W'(1);
        end
      end
      // one result held back so the final one can be marked
      if (hit) begin
        if (pend_vld_r) begin
          out_valid_nxt  = 1'b1;
          out_sensor_nxt = pend_idx_r;
          out_rate_nxt   = pend_cls_r;
          out_last_nxt   = 1'b0;
        end
        pend_vld_nxt = 1'b1;
        pend_idx_nxt = hit_idx4;
        pend_cls_nxt = rd_cls_r;
        res_cnt_nxt  = res_cnt_r + 5'd1;
      end
    end

    if (cmd.flush) begin
      if (pend_vld_r) begin
        out_valid_nxt  = 1'b1;
        out_sensor_nxt = pend_idx_r;
        out_rate_nxt   = pend_cls_r;
        out_last_nxt   = 1'b1;
      end
      pend_vld_nxt = 1'b0;
    end
  end

  // rate memory, registered read
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      rate_mem[total_r[IDX_W-1:0]] <= in_sensor_rate;
    end
    if (cmd.scan && iss_act_r) begin
      rd_data_r <= rate_mem[rd_addr_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpt_r       <= MICROS_PER_TICK_RST;
      prev_r      <= '0;
      acc_r       <= '0;
      milli_r     <= '0;
      mark10_r    <= '0;
      mark100_r   <= '0;
      total_r     <= '0;
      iss_act_r   <= 1'b0;
      rd_vld_r    <= 1'b0;
      pend_vld_r  <= 1'b0;
      res_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mpt_r       <= mpt_nxt;
      prev_r      <= prev_nxt;
      acc_r       <= acc_nxt;
      milli_r     <= milli_nxt;
      mark10_r    <= mark10_nxt;
      mark100_r   <= mark100_nxt;
      total_r     <= total_nxt;
      iss_act_r   <= iss_act_nxt;
      rd_vld_r    <= rd_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      res_cnt_r   <= res_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stamp_r      <= stamp_nxt;
    delta_r      <= delta_nxt;
    due_r        <= due_nxt;
    rd_addr_r    <= rd_addr_nxt;
    cls_r        <= cls_nxt;
    rd_idx_r     <= rd_idx_nxt;
    rd_cls_r     <= rd_cls_nxt;
    pend_idx_r   <= pend_idx_nxt;
    pend_cls_r   <= pend_cls_nxt;
    out_sensor_r <= out_sensor_nxt;
    out_rate_r   <= out_rate_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign stat.tick      = tick;
  assign stat.scan_done = !iss_act_r && !rd_vld_r;

  assign out_valid       = out_valid_r;
  assign out_due_sensor  = out_sensor_r;
  assign out_due_rate    = out_rate_r;
  assign out_last_of_run = out_last_r;

endmodule

// ===== rtl/multi_rate_sensor_dispatcher_unit.sv =====
// top level of the multi-rate sensor dispatcher
//
// input channel: a transaction is taken when start is high and busy is low.
//   in_op selects a timestamp sample or a sensor registration.
// registration: stored in the same cycle, busy never rises, no results.
//   a full sensor table ignores it.
// timestamp: busy through the delta, accumulate and check states when no
//   tick occurs. on a tick the table is scanned once for every due rate
//   class (1 ms always, 10 ms, 100 ms and 1 s when due), one entry per
//   cycle out of the rate memory, in the flags, scan and flush states.
// results: out_valid strobes for one cycle per due sensor, up to 16 per
//   tick, with its index and rate class; out_last_of_run marks the final
//   one of the tick. the last result appears in the first cycle busy is low.
//   the receiver cannot stall; results have no ready handshake.
// config: cfg_data sets micros_per_tick when cfg_valid and cfg_ready are
//   high; cfg_ready is high while the block is idle.
// reset: rst_n low clears prev stamp, accumulator, ms counters, sensor
//   count; tick threshold back to 1000 us; no clearing pass is needed.
module multi_rate_sensor_dispatcher_unit
  import mrsd_pkg::*;
#(
  parameter int MAX_SENSORS = MAX_SENSORS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [31:0] in_timestamp_us,
  input  logic [1:0]  in_sensor_rate,
  output logic        out_valid,
  output logic [3:0]  out_due_sensor,
  output logic [1:0]  out_due_rate,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = !busy;

  mrsd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  mrsd_datapath #(
    .MAX_SENSORS (MAX_SENSORS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_timestamp_us (in_timestamp_us),
    .in_sensor_rate  (in_sensor_rate),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_due_sensor  (out_due_sensor),
    .out_due_rate    (out_due_rate),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== rtl/mrsd_checker.sv =====
// port-level assertions for the multi-rate sensor dispatcher, with bind
module mrsd_checker
  import mrsd_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_op,
  input logic out_valid,
  input logic out_last_of_run
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

  a_register_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op == OP_REGISTER)) |=> !busy)
    else $error("registration transaction made the block busy");

  a_stamp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op == OP_STAMP)) |=> busy)
    else $error("timestamp transaction did not start work");

  a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |=> busy)
    else $error("run ended without a last result");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_run) |=> !out_valid)
    else $error("result right after the last of a run");

endmodule

bind multi_rate_sensor_dispatcher_unit mrsd_checker u_mrsd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_op           (in_op),
  .out_valid       (out_valid),
  .out_last_of_run (out_last_of_run)
);
